@@ hw/rtl/rc2_pkg.sv @@
// ----------------------------------------------------------------------------
// rc2_pkg
// Shared types, codes and the permutation table of the RC2 block cipher unit.
// ----------------------------------------------------------------------------
package rc2_pkg;

    localparam int KEY_BUFFER_BYTES = 128;
    localparam int KB_ADDR_W        = 7;
    localparam int SUBKEY_COUNT     = 64;
    localparam int SK_ADDR_W        = 6;
    localparam int WORD_W           = 16;
    localparam int BLOCK_W          = 64;
    localparam int KEY_LEN_W        = 8;
    localparam int EFF_BITS_W       = 11;
    localparam int CFG_DATA_W       = 11;

    localparam logic [KEY_LEN_W-1:0]  KEY_LEN_RESET  = 8'd8;
    localparam logic [EFF_BITS_W-1:0] EFF_BITS_RESET = 11'd64;

    // rounds followed (encrypt) or preceded (decrypt) by a mash pass
    localparam logic [3:0] MASH_ROUND_A = 4'd4;
    localparam logic [3:0] MASH_ROUND_B = 4'd10;

    typedef enum logic [1:0] {
        OP_LOAD    = 2'd0,
        OP_EXPAND  = 2'd1,
        OP_ENCRYPT = 2'd2,
        OP_DECRYPT = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NO_KEY  = 2'd1,
        ST_KEY_SET = 2'd2
    } status_t;

    typedef enum logic {
        CFG_KEY_LEN  = 1'b0,
        CFG_EFF_BITS = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0] {
        CTL_IDLE,
        CTL_EXPAND,
        CTL_CRYPT,
        CTL_RESP
    } ctl_state_t;

    typedef enum logic [3:0] {
        KS_IDLE,
        KS_PRE_RD,
        KS_PRE_WT,
        KS_FILL_RD,
        KS_FILL_WR,
        KS_RED_RD,
        KS_RED_WR,
        KS_BACK_RD,
        KS_BACK_WR,
        KS_SK_A,
        KS_SK_B,
        KS_SK_C
    } ks_state_t;

    typedef enum logic [1:0] {
        CR_IDLE,
        CR_RD,
        CR_EX
    } cr_state_t;

    typedef struct packed {
        logic                 we;
        logic [KB_ADDR_W-1:0] addr;
        logic [7:0]           data;
    } kb_wr_t;

    typedef struct packed {
        logic                 we;
        logic [SK_ADDR_W-1:0] addr;
        logic [WORD_W-1:0]    data;
    } sk_wr_t;

    localparam logic [7:0] PI_TABLE [256] = '{
        8'hd9,8'h78,8'hf9,8'hc4,8'h19,8'hdd,8'hb5,8'hed,
        8'h28,8'he9,8'hfd,8'h79,8'h4a,8'ha0,8'hd8,8'h9d,
        8'hc6,8'h7e,8'h37,8'h83,8'h2b,8'h76,8'h53,8'h8e,
        8'h62,8'h4c,8'h64,8'h88,8'h44,8'h8b,8'hfb,8'ha2,
        8'h17,8'h9a,8'h59,8'hf5,8'h87,8'hb3,8'h4f,8'h13,
        8'h61,8'h45,8'h6d,8'h8d,8'h09,8'h81,8'h7d,8'h32,
        8'hbd,8'h8f,8'h40,8'heb,8'h86,8'hb7,8'h7b,8'h0b,
        8'hf0,8'h95,8'h21,8'h22,8'h5c,8'h6b,8'h4e,8'h82,
        8'h54,8'hd6,8'h65,8'h93,8'hce,8'h60,8'hb2,8'h1c,
        8'h73,8'h56,8'hc0,8'h14,8'ha7,8'h8c,8'hf1,8'hdc,
        8'h12,8'h75,8'hca,8'h1f,8'h3b,8'hbe,8'he4,8'hd1,
        8'h42,8'h3d,8'hd4,8'h30,8'ha3,8'h3c,8'hb6,8'h26,
        8'h6f,8'hbf,8'h0e,8'hda,8'h46,8'h69,8'h07,8'h57,
        8'h27,8'hf2,8'h1d,8'h9b,8'hbc,8'h94,8'h43,8'h03,
        8'hf8,8'h11,8'hc7,8'hf6,8'h90,8'hef,8'h3e,8'he7,
        8'h06,8'hc3,8'hd5,8'h2f,8'hc8,8'h66,8'h1e,8'hd7,
        8'h08,8'he8,8'hea,8'hde,8'h80,8'h52,8'hee,8'hf7,
        8'h84,8'haa,8'h72,8'hac,8'h35,8'h4d,8'h6a,8'h2a,
        8'h96,8'h1a,8'hd2,8'h71,8'h5a,8'h15,8'h49,8'h74,
        8'h4b,8'h9f,8'hd0,8'h5e,8'h04,8'h18,8'ha4,8'hec,
        8'hc2,8'he0,8'h41,8'h6e,8'h0f,8'h51,8'hcb,8'hcc,
        8'h24,8'h91,8'haf,8'h50,8'ha1,8'hf4,8'h70,8'h39,
        8'h99,8'h7c,8'h3a,8'h85,8'h23,8'hb8,8'hb4,8'h7a,
        8'hfc,8'h02,8'h36,8'h5b,8'h25,8'h55,8'h97,8'h31,
        8'h2d,8'h5d,8'hfa,8'h98,8'he3,8'h8a,8'h92,8'hae,
        8'h05,8'hdf,8'h29,8'h10,8'h67,8'h6c,8'hba,8'hc9,
        8'hd3,8'h00,8'he6,8'hcf,8'he1,8'h9e,8'ha8,8'h2c,
        8'h63,8'h16,8'h01,8'h3f,8'h58,8'he2,8'h89,8'ha9,
        8'h0d,8'h38,8'h34,8'h1b,8'hab,8'h33,8'hff,8'hb0,
        8'hbb,8'h48,8'h0c,8'h5f,8'hb9,8'hb1,8'hcd,8'h2e,
        8'hc5,8'hf3,8'hdb,8'h47,8'he5,8'ha5,8'h9c,8'h77,
        8'h0a,8'ha6,8'h20,8'h68,8'hfe,8'h7f,8'hc1,8'had
    };

endpackage

@@ hw/rtl/rc2_block_cipher_unit.sv @@
// ----------------------------------------------------------------------------
// rc2_block_cipher_unit
// RC2 block cipher with key buffer, key expansion and encrypt/decrypt.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) carries one command word: load a key
// byte, expand the key, encrypt or decrypt a 64-bit block. Output channel
// (out_valid/out_ready) returns result_block and status for every command
// but a key load.
// Steps from acceptance to out_valid:
//   load key byte   : no result word.
//   encrypt/decrypt : the round word unit does one mix per cycle (64
//                     mixes), each of the 8 mash steps takes a subkey read
//                     and an update, plus fetch, start and result steps.
//   expand          : set by the key buffer: one read and one write per
//                     byte, then two byte reads and one write per subkey.
//   errors          : go straight to the result word; no unit runs.
// One command at a time: in_ready is low from acceptance until the result
// word is placed in the output register. A word waiting in that register
// does not block the next command; a stalled receiver holds the block only
// once a second result is ready.
// Reset clears the key-expanded flag and loads the configuration defaults
// (8 key bytes, 64 effective bits); key buffer and subkeys are undefined
// until loaded and expanded. Write configuration only while idle.
module rc2_block_cipher_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          operation,
    input  logic [6:0]                          key_position,
    input  logic [7:0]                          key_byte,
    input  logic [63:0]                         data_block,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [63:0]                         result_block,
    output logic [1:0]                          status,
    input  logic                                cfg_write,
    input  logic                                cfg_index,
    input  logic [rc2_pkg::CFG_DATA_W-1:0]      cfg_data
);

    rc2_pkg::ctl_state_t state_reg, state_next;

    logic [rc2_pkg::KEY_LEN_W-1:0]  key_len_reg;
    logic [rc2_pkg::EFF_BITS_W-1:0] eff_bits_reg;
    logic                           key_ready_reg;
    logic [1:0]                     pend_status_reg;
    logic                           pend_zero_reg;
    logic                           out_valid_reg;
    logic [63:0]                    out_block_reg;
    logic [1:0]                     out_status_reg;

    logic            in_fire;
    logic            slot_free;
    logic            ks_start;
    logic            ks_done;
    logic            cr_start;
    logic            cr_done;
    rc2_pkg::kb_wr_t kb_load;
    rc2_pkg::sk_wr_t sk_wr;
    logic [rc2_pkg::SK_ADDR_W-1:0] sk_raddr;
    logic [rc2_pkg::WORD_W-1:0]    sk_rdata;
    logic [63:0]                   cr_block;

    assign in_fire   = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rc2_pkg::CTL_IDLE:
            begin
                if (in_valid)
                begin
                    case (operation)
                        rc2_pkg::OP_LOAD:
                            state_next = rc2_pkg::CTL_IDLE;
                        rc2_pkg::OP_EXPAND:
                            state_next = key_ready_reg ? rc2_pkg::CTL_RESP
                                                       : rc2_pkg::CTL_EXPAND;
                        default:
                            state_next = key_ready_reg ? rc2_pkg::CTL_CRYPT
                                                       : rc2_pkg::CTL_RESP;
                    endcase
                end
            end
            rc2_pkg::CTL_EXPAND:
            begin
                if (ks_done)
                    state_next = rc2_pkg::CTL_RESP;
            end
            rc2_pkg::CTL_CRYPT:
            begin
                if (cr_done)
                    state_next = rc2_pkg::CTL_RESP;
            end
            rc2_pkg::CTL_RESP:
            begin
                if (slot_free)
                    state_next = rc2_pkg::CTL_IDLE;
            end
            default: state_next = rc2_pkg::CTL_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready = 1'b0;
        ks_start = 1'b0;
        cr_start = 1'b0;
        kb_load  = '0;
        case (state_reg)
            rc2_pkg::CTL_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    case (operation)
                        rc2_pkg::OP_LOAD:
                        begin
                            kb_load.we   = 1'b1;
                            kb_load.addr = key_position;
                            kb_load.data = key_byte;
                        end
                        rc2_pkg::OP_EXPAND: ks_start = !key_ready_reg;
                        default:            cr_start = key_ready_reg;
                    endcase
                end
            end
            default: in_ready = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rc2_pkg::CTL_IDLE;
            key_len_reg   <= rc2_pkg::KEY_LEN_RESET;
            eff_bits_reg  <= rc2_pkg::EFF_BITS_RESET;
            key_ready_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    rc2_pkg::CFG_KEY_LEN:
                        key_len_reg <= cfg_data[rc2_pkg::KEY_LEN_W-1:0];
                    default:
                        eff_bits_reg <= cfg_data[rc2_pkg::EFF_BITS_W-1:0];
                endcase
            end
            if (ks_done)
                key_ready_reg <= 1'b1;
            if (state_reg == rc2_pkg::CTL_RESP && slot_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            pend_zero_reg <= 1'b1;
            if (operation == rc2_pkg::OP_EXPAND)
                pend_status_reg <= key_ready_reg ? rc2_pkg::ST_KEY_SET : rc2_pkg::ST_OK;
            else
                pend_status_reg <= key_ready_reg ? rc2_pkg::ST_OK : rc2_pkg::ST_NO_KEY;
        end
        else if (cr_done)
        begin
            pend_zero_reg <= 1'b0;
        end
        if (state_reg == rc2_pkg::CTL_RESP && slot_free)
        begin
            out_block_reg  <= pend_zero_reg ? 64'd0 : cr_block;
            out_status_reg <= pend_status_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_block = out_block_reg;
    assign status       = out_status_reg;

    rc2_key_sched u_key_sched (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (ks_start),
        .kb_load          (kb_load),
        .key_length_bytes (key_len_reg),
        .effective_bits   (eff_bits_reg),
        .sk_wr            (sk_wr),
        .done             (ks_done)
    );

    rc2_ram #(
        .WIDTH (rc2_pkg::WORD_W),
        .DEPTH (rc2_pkg::SUBKEY_COUNT)
    ) u_subkeys (
        .clk   (clk),
        .we    (sk_wr.we),
        .waddr (sk_wr.addr),
        .wdata (sk_wr.data),
        .raddr (sk_raddr),
        .rdata (sk_rdata)
    );

    rc2_crypt_core u_crypt_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cr_start),
        .decrypt   (operation == rc2_pkg::OP_DECRYPT),
        .block_in  (data_block),
        .sk_raddr  (sk_raddr),
        .sk_rdata  (sk_rdata),
        .block_out (cr_block),
        .done      (cr_done)
    );

    // expansion runs only once per reset
    assert property (@(posedge clk) disable iff (!rst_n)
        ks_start |-> !key_ready_reg)
        else $error("key expansion started with key already expanded");

    assert property (@(posedge clk) disable iff (!rst_n)
        ks_done |=> key_ready_reg && state_reg == rc2_pkg::CTL_RESP)
        else $error("expansion finish not followed by result");

    assert property (@(posedge clk) disable iff (!rst_n)
        cr_done |-> state_reg == rc2_pkg::CTL_CRYPT && key_ready_reg)
        else $error("cipher finished outside a cipher command");

    assert property (@(posedge clk) disable iff (!rst_n)
        cr_start |-> key_ready_reg && !ks_start)
        else $error("cipher started without an expanded key");

endmodule

@@ hw/rtl/rc2_ram.sv @@
// ----------------------------------------------------------------------------
// rc2_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module rc2_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/rc2_key_sched.sv @@
// ----------------------------------------------------------------------------
// rc2_key_sched
// Key buffer and key expansion sequencer: fill, reduce and back-propagate
// the expanded key in place, then pack it into the subkey store.
// ----------------------------------------------------------------------------
module rc2_key_sched (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  rc2_pkg::kb_wr_t                     kb_load,
    input  logic [rc2_pkg::KEY_LEN_W-1:0]       key_length_bytes,
    input  logic [rc2_pkg::EFF_BITS_W-1:0]      effective_bits,
    output rc2_pkg::sk_wr_t                     sk_wr,
    output logic                                done
);

    rc2_pkg::ks_state_t state_reg, state_next;

    logic [7:0] i_reg;
    logic [7:0] prev_reg;
    logic [7:0] lo_reg;
    logic [7:0] t_reg;
    logic [7:0] t8_reg;
    logic [7:0] tm_reg;

    logic [7:0]  t_c;
    logic [10:0] t1_c;
    logic [10:0] t1_round;
    logic [7:0]  t8_c;
    logic [10:0] t8x8;
    logic [10:0] pad_bits;
    logic [7:0]  tm_c;

    logic [7:0]  pi_idx;
    logic [7:0]  pi_val;
    logic [7:0]  red_pos;
    logic [7:0]  raddr_full;
    logic [rc2_pkg::KB_ADDR_W-1:0] kb_raddr;
    logic [7:0]  kb_rdata;
    rc2_pkg::kb_wr_t kb_wr;

    // clamp the key length and effective bits into their legal ranges
    always_comb
    begin
        if (key_length_bytes == 8'd0)
            t_c = 8'd1;
        else if (key_length_bytes > 8'd128)
            t_c = 8'd128;
        else
            t_c = key_length_bytes;

        if (effective_bits == 11'd0)
            t1_c = 11'd1;
        else if (effective_bits > 11'd1024)
            t1_c = 11'd1024;
        else
            t1_c = effective_bits;

        t1_round = t1_c + 11'd7;
        t8_c     = t1_round[10:3];
        t8x8     = {t8_c, 3'b000};
        pad_bits = t8x8 - t1_c;
        tm_c     = 8'hFF >> pad_bits[2:0];
    end

    assign red_pos = 8'd128 - t8_reg;

    always_comb
    begin
        case (state_reg)
            rc2_pkg::KS_FILL_WR: pi_idx = prev_reg + kb_rdata;
            rc2_pkg::KS_RED_WR:  pi_idx = kb_rdata & tm_reg;
            default:             pi_idx = prev_reg ^ kb_rdata;
        endcase
        pi_val = rc2_pkg::PI_TABLE[pi_idx];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rc2_pkg::KS_IDLE:
            begin
                if (start)
                    state_next = (t_c == 8'd128) ? rc2_pkg::KS_RED_RD : rc2_pkg::KS_PRE_RD;
            end
            rc2_pkg::KS_PRE_RD:  state_next = rc2_pkg::KS_PRE_WT;
            rc2_pkg::KS_PRE_WT:  state_next = rc2_pkg::KS_FILL_RD;
            rc2_pkg::KS_FILL_RD: state_next = rc2_pkg::KS_FILL_WR;
            rc2_pkg::KS_FILL_WR:
                state_next = (i_reg == 8'd127) ? rc2_pkg::KS_RED_RD : rc2_pkg::KS_FILL_RD;
            rc2_pkg::KS_RED_RD:  state_next = rc2_pkg::KS_RED_WR;
            rc2_pkg::KS_RED_WR:
                state_next = (t8_reg == 8'd128) ? rc2_pkg::KS_SK_A : rc2_pkg::KS_BACK_RD;
            rc2_pkg::KS_BACK_RD: state_next = rc2_pkg::KS_BACK_WR;
            rc2_pkg::KS_BACK_WR:
                state_next = (i_reg == 8'd0) ? rc2_pkg::KS_SK_A : rc2_pkg::KS_BACK_RD;
            rc2_pkg::KS_SK_A:    state_next = rc2_pkg::KS_SK_B;
            rc2_pkg::KS_SK_B:    state_next = rc2_pkg::KS_SK_C;
            rc2_pkg::KS_SK_C:
                state_next = (i_reg[5:0] == 6'd63) ? rc2_pkg::KS_IDLE : rc2_pkg::KS_SK_A;
            default:             state_next = rc2_pkg::KS_IDLE;
        endcase
    end

    // outputs: buffer addresses and write ports
    always_comb
    begin
        raddr_full  = 8'd0;
        kb_wr       = '0;
        sk_wr       = '0;
        done        = 1'b0;
        case (state_reg)
            rc2_pkg::KS_IDLE:    kb_wr = kb_load;
            rc2_pkg::KS_PRE_RD:  raddr_full = t_reg - 8'd1;
            rc2_pkg::KS_FILL_RD: raddr_full = i_reg - t_reg;
            rc2_pkg::KS_FILL_WR:
            begin
                kb_wr.we   = 1'b1;
                kb_wr.addr = i_reg[rc2_pkg::KB_ADDR_W-1:0];
                kb_wr.data = pi_val;
            end
            rc2_pkg::KS_RED_RD:  raddr_full = red_pos;
            rc2_pkg::KS_RED_WR:
            begin
                kb_wr.we   = 1'b1;
                kb_wr.addr = red_pos[rc2_pkg::KB_ADDR_W-1:0];
                kb_wr.data = pi_val;
            end
            rc2_pkg::KS_BACK_RD: raddr_full = i_reg + t8_reg;
            rc2_pkg::KS_BACK_WR:
            begin
                kb_wr.we   = 1'b1;
                kb_wr.addr = i_reg[rc2_pkg::KB_ADDR_W-1:0];
                kb_wr.data = pi_val;
            end
            rc2_pkg::KS_SK_A:    raddr_full = {1'b0, i_reg[5:0], 1'b0};
            rc2_pkg::KS_SK_B:    raddr_full = {1'b0, i_reg[5:0], 1'b1};
            rc2_pkg::KS_SK_C:
            begin
                sk_wr.we   = 1'b1;
                sk_wr.addr = i_reg[rc2_pkg::SK_ADDR_W-1:0];
                sk_wr.data = {kb_rdata, lo_reg};
                done       = (i_reg[5:0] == 6'd63);
            end
            default:             raddr_full = 8'd0;
        endcase
    end

    assign kb_raddr = raddr_full[rc2_pkg::KB_ADDR_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= rc2_pkg::KS_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            rc2_pkg::KS_IDLE:
            begin
                if (start)
                begin
                    t_reg  <= t_c;
                    t8_reg <= t8_c;
                    tm_reg <= tm_c;
                    i_reg  <= t_c;
                end
            end
            rc2_pkg::KS_PRE_WT:  prev_reg <= kb_rdata;
            rc2_pkg::KS_FILL_WR:
            begin
                prev_reg <= pi_val;
                i_reg    <= i_reg + 8'd1;
            end
            rc2_pkg::KS_RED_WR:
            begin
                prev_reg <= pi_val;
                // start the backward pass just below the reduced byte
                i_reg    <= (t8_reg == 8'd128) ? 8'd0 : (8'd127 - t8_reg);
            end
            rc2_pkg::KS_BACK_WR:
            begin
                prev_reg <= pi_val;
                i_reg    <= (i_reg == 8'd0) ? 8'd0 : (i_reg - 8'd1);
            end
            rc2_pkg::KS_SK_B:    lo_reg <= kb_rdata;
            rc2_pkg::KS_SK_C:    i_reg  <= i_reg + 8'd1;
            default:             i_reg  <= i_reg;
        endcase
    end

    rc2_ram #(
        .WIDTH (8),
        .DEPTH (rc2_pkg::KEY_BUFFER_BYTES)
    ) u_key_buffer (
        .clk   (clk),
        .we    (kb_wr.we),
        .waddr (kb_wr.addr),
        .wdata (kb_wr.data),
        .raddr (kb_raddr),
        .rdata (kb_rdata)
    );

endmodule

@@ hw/rtl/rc2_crypt_core.sv @@
// ----------------------------------------------------------------------------
// rc2_crypt_core
// Round sequencer around one shared word update unit: one mix or mash step
// per pass, subkeys fetched from the subkey store.
// ----------------------------------------------------------------------------
module rc2_crypt_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic                                decrypt,
    input  logic [rc2_pkg::BLOCK_W-1:0]         block_in,
    output logic [rc2_pkg::SK_ADDR_W-1:0]       sk_raddr,
    input  logic [rc2_pkg::WORD_W-1:0]          sk_rdata,
    output logic [rc2_pkg::BLOCK_W-1:0]         block_out,
    output logic                                done
);

    rc2_pkg::cr_state_t state_reg, state_next;

    logic [rc2_pkg::WORD_W-1:0] rw_reg [4];
    logic [3:0] rnd_reg;
    logic [1:0] idx_reg;
    logic       mash_reg;
    logic       dec_reg;

    logic [3:0] nx_rnd;
    logic [1:0] nx_idx;
    logic       nx_mash;
    logic       last_step;
    logic [3:0] rnd_dn;

    logic [rc2_pkg::WORD_W-1:0] wa, wb, wc, ww;
    logic [rc2_pkg::WORD_W-1:0] term;
    logic [rc2_pkg::WORD_W-1:0] opnd;
    logic [rc2_pkg::WORD_W-1:0] base;
    logic [rc2_pkg::WORD_W-1:0] sum;
    logic [rc2_pkg::WORD_W-1:0] word_new;

    function automatic logic [15:0] rot_left(input logic [15:0] v, input logic [1:0] i);
        logic [15:0] r;
        case (i)
            2'd0:    r = {v[14:0], v[15]};
            2'd1:    r = {v[13:0], v[15:14]};
            2'd2:    r = {v[12:0], v[15:13]};
            default: r = {v[10:0], v[15:11]};
        endcase
        return r;
    endfunction

    function automatic logic [15:0] rot_right(input logic [15:0] v, input logic [1:0] i);
        logic [15:0] r;
        case (i)
            2'd0:    r = {v[0], v[15:1]};
            2'd1:    r = {v[1:0], v[15:2]};
            2'd2:    r = {v[2:0], v[15:3]};
            default: r = {v[4:0], v[15:5]};
        endcase
        return r;
    endfunction

    // shared word update unit
    always_comb
    begin
        ww   = rw_reg[idx_reg];
        wc   = rw_reg[idx_reg + 2'd1];
        wb   = rw_reg[idx_reg + 2'd2];
        wa   = rw_reg[idx_reg + 2'd3];
        term = (wa & wb) + (~wa & wc);
        opnd = mash_reg ? '0 : term;
        base = (dec_reg && !mash_reg) ? rot_right(ww, idx_reg) : ww;
        if (dec_reg)
            sum = base - sk_rdata - opnd;
        else
            sum = base + sk_rdata + opnd;
        word_new = (!dec_reg && !mash_reg) ? rot_left(sum, idx_reg) : sum;
    end

    // step order: encrypt runs rounds upward with mash after its mixes,
    // decrypt runs downward with mash before its mixes
    always_comb
    begin
        rnd_dn    = rnd_reg - 4'd1;
        nx_rnd    = rnd_reg;
        nx_idx    = idx_reg;
        nx_mash   = mash_reg;
        last_step = 1'b0;
        if (!dec_reg)
        begin
            nx_idx = idx_reg + 2'd1;
            if (idx_reg == 2'd3)
            begin
                if (!mash_reg && (rnd_reg == rc2_pkg::MASH_ROUND_A ||
                                  rnd_reg == rc2_pkg::MASH_ROUND_B))
                begin
                    nx_mash = 1'b1;
                end
                else
                begin
                    nx_mash   = 1'b0;
                    nx_rnd    = rnd_reg + 4'd1;
                    last_step = (rnd_reg == 4'd15);
                end
            end
        end
        else
        begin
            nx_idx = idx_reg - 2'd1;
            if (idx_reg == 2'd0)
            begin
                if (mash_reg)
                begin
                    nx_mash = 1'b0;
                end
                else
                begin
                    nx_rnd    = rnd_dn;
                    nx_mash   = (rnd_dn == rc2_pkg::MASH_ROUND_A ||
                                 rnd_dn == rc2_pkg::MASH_ROUND_B);
                    last_step = (rnd_reg == 4'd0);
                end
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rc2_pkg::CR_IDLE:
            begin
                if (start)
                    state_next = rc2_pkg::CR_RD;
            end
            rc2_pkg::CR_RD: state_next = rc2_pkg::CR_EX;
            rc2_pkg::CR_EX:
            begin
                if (last_step)
                    state_next = rc2_pkg::CR_IDLE;
                else if (nx_mash)
                    state_next = rc2_pkg::CR_RD;
                else
                    state_next = rc2_pkg::CR_EX;
            end
            default:        state_next = rc2_pkg::CR_IDLE;
        endcase
    end

    // outputs: a mash address depends on the word just written, so it is
    // fetched in a read pass of its own; mix addresses are fetched ahead
    always_comb
    begin
        sk_raddr = '0;
        done     = 1'b0;
        case (state_reg)
            rc2_pkg::CR_RD:
                sk_raddr = mash_reg ? rw_reg[idx_reg + 2'd3][rc2_pkg::SK_ADDR_W-1:0]
                                    : {rnd_reg, idx_reg};
            rc2_pkg::CR_EX:
            begin
                sk_raddr = {nx_rnd, nx_idx};
                done     = last_step;
            end
            default: sk_raddr = '0;
        endcase
    end

    assign block_out = {rw_reg[3], rw_reg[2], rw_reg[1], rw_reg[0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= rc2_pkg::CR_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rw_reg[0] <= '0;
            rw_reg[1] <= '0;
            rw_reg[2] <= '0;
            rw_reg[3] <= '0;
        end
        else if (state_reg == rc2_pkg::CR_IDLE && start)
        begin
            rw_reg[0] <= block_in[15:0];
            rw_reg[1] <= block_in[31:16];
            rw_reg[2] <= block_in[47:32];
            rw_reg[3] <= block_in[63:48];
        end
        else if (state_reg == rc2_pkg::CR_EX)
        begin
            rw_reg[idx_reg] <= word_new;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == rc2_pkg::CR_IDLE && start)
        begin
            dec_reg  <= decrypt;
            rnd_reg  <= decrypt ? 4'd15 : 4'd0;
            idx_reg  <= decrypt ? 2'd3 : 2'd0;
            mash_reg <= 1'b0;
        end
        else if (state_reg == rc2_pkg::CR_EX)
        begin
            rnd_reg  <= nx_rnd;
            idx_reg  <= nx_idx;
            mash_reg <= nx_mash;
        end
    end

endmodule

@@ tb/tb_rc2_block_cipher_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rc2_block_cipher_unit
// Self-checking bench for the RC2 cipher unit. Command words are driven on
// the input channel with random gaps. Results are taken with random receiver
// stalls and compared with a scoreboard that runs its own key schedule and
// block rounds. Register settings change between phases, while the unit is
// idle.
// ----------------------------------------------------------------------------
module tb_rc2_block_cipher_unit;
    import rc2_pkg::*;

    localparam int STALL_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 20;
    localparam int MASH_AFTER_A  = 4;
    localparam int MASH_AFTER_B  = 10;

    // permutation bytes, entry 0 in the top byte
    localparam bit [2047:0] PI_BYTES = {
        128'hd978f9c419ddb5ed28e9fd794aa0d89d,
        128'hc67e37832b76538e624c6488448bfba2,
        128'h179a59f587b34f1361456d8d09817d32,
        128'hbd8f40eb86b77b0bf09521225c6b4e82,
        128'h54d66593ce60b21c7356c014a78cf1dc,
        128'h1275ca1f3bbee4d1423dd430a33cb626,
        128'h6fbf0eda4669075727f21d9bbc944303,
        128'hf811c7f690ef3ee706c3d52fc8661ed7,
        128'h08e8eade8052eef784aa72ac354d6a2a,
        128'h961ad2715a1549744b9fd05e0418a4ec,
        128'hc2e0416e0f51cbcc2491af50a1f47039,
        128'h997c3a8523b8b47afc02365b25559731,
        128'h2d5dfa98e38a92ae05df2910676cbac9,
        128'hd300e6cfe19ea82c6316013f58e289a9,
        128'h0d38341bab33ffb0bb480c5fb9b1cd2e,
        128'hc5f3db47e5a59c770aa62068fe7fc1ad
    };

    typedef struct packed {
        logic [BLOCK_W-1:0] blk;
        status_t            st;
    } cipher_word_t;

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  in_valid     = 1'b0;
    logic                  in_ready;
    logic [1:0]            operation    = OP_LOAD;
    logic [6:0]            key_position = '0;
    logic [7:0]            key_byte     = '0;
    logic [63:0]           data_block   = '0;
    logic                  out_valid;
    logic                  out_ready    = 1'b1;
    logic [63:0]           result_block;
    logic [1:0]            status;
    logic                  cfg_write    = 1'b0;
    logic                  cfg_index    = CFG_KEY_LEN;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;

    class rc2_scoreboard;
        bit [7:0]     key_mem [KEY_BUFFER_BYTES];
        bit           loaded [KEY_BUFFER_BYTES];
        bit [15:0]    subkey [SUBKEY_COUNT];
        bit [15:0]    rw [4];
        int           rot [4];
        bit           expanded;
        bit [7:0]     key_len;
        bit [10:0]    eff_bits;
        bit [63:0]    last_cipher;
        cipher_word_t pending_words [$];
        int           errors;

        function new();
            expanded    = 1'b0;
            key_len     = KEY_LEN_RESET;
            eff_bits    = EFF_BITS_RESET;
            last_cipher = '0;
            errors      = 0;
            rot         = '{1, 2, 3, 5};
            foreach (loaded[i]) loaded[i] = 1'b0;
        endfunction

        function void write_reg(bit [7:0] len_val, bit [10:0] eff_val);
            key_len  = len_val;
            eff_bits = eff_val;
        endfunction

        function bit [7:0] pi_of(bit [7:0] x);
            return PI_BYTES[2047 - 8 * int'(x) -: 8];
        endfunction

        function void expand_subkeys();
            bit [7:0] l [128];
            bit [7:0] tm;
            int       t, t1, t8;
            t  = key_len;
            t1 = eff_bits;
            if (t == 0) t = 1;
            if (t > 128) t = 128;
            if (t1 == 0) t1 = 1;
            if (t1 > 1024) t1 = 1024;
            t8 = (t1 + 7) >> 3;
            tm = 8'hFF >> ((t8 << 3) - t1);
            for (int i = 0; i < 128; i++) l[i] = (i < t) ? key_mem[i] : 8'h00;
            for (int i = t; i < 128; i++) l[i] = pi_of(l[i - 1] + l[i - t]);
            l[128 - t8] = pi_of(l[128 - t8] & tm);
            for (int i = 127 - t8; i >= 0; i--) l[i] = pi_of(l[i + 1] ^ l[i + t8]);
            for (int i = 0; i < 64; i++) subkey[i] = {l[2 * i + 1], l[2 * i]};
            expanded = 1'b1;
        endfunction

        function bit [15:0] mix_term(int i);
            bit [15:0] a, b, c;
            a = rw[(i + 3) % 4];
            b = rw[(i + 2) % 4];
            c = rw[(i + 1) % 4];
            return (a & b) + (~a & c);
        endfunction

        function bit [63:0] run_block(bit [63:0] blk, bit dec);
            bit [15:0] v;
            for (int w = 0; w < 4; w++) rw[w] = blk[16 * w +: 16];
            if (!dec)
            begin
                for (int r = 0; r < 16; r++)
                begin
                    for (int i = 0; i < 4; i++)
                    begin
                        v     = rw[i] + subkey[(4 * r + i) % 64] + mix_term(i);
                        rw[i] = (v << rot[i]) | (v >> (16 - rot[i]));
                    end
                    if (r == MASH_AFTER_A || r == MASH_AFTER_B)
                        for (int i = 0; i < 4; i++)
                            rw[i] = rw[i] + subkey[rw[(i + 3) % 4][5:0]];
                end
            end
            else
            begin
                // undo the rounds last to first, words 3 down to 0
                for (int r = 15; r >= 0; r--)
                begin
                    if (r == MASH_AFTER_A || r == MASH_AFTER_B)
                        for (int i = 3; i >= 0; i--)
                            rw[i] = rw[i] - subkey[rw[(i + 3) % 4][5:0]];
                    for (int i = 3; i >= 0; i--)
                    begin
                        v     = (rw[i] >> rot[i]) | (rw[i] << (16 - rot[i]));
                        rw[i] = v - subkey[(4 * r + i) % 64] - mix_term(i);
                    end
                end
            end
            return {rw[3], rw[2], rw[1], rw[0]};
        endfunction

        function void note_input(op_t op, bit [6:0] pos, bit [7:0] kb, bit [63:0] blk);
            cipher_word_t w;
            if (op == OP_LOAD)
            begin
                key_mem[pos] = kb;
                loaded[pos]  = 1'b1;
                return;
            end
            w.blk = '0;
            w.st  = ST_OK;
            if (op == OP_EXPAND)
            begin
                if (expanded) w.st = ST_KEY_SET;
                else expand_subkeys();
            end
            else if (!expanded)
            begin
                w.st = ST_NO_KEY;
            end
            else
            begin
                w.blk = run_block(blk, op == OP_DECRYPT);
                if (op == OP_ENCRYPT) last_cipher = w.blk;
            end
            pending_words = {pending_words, w};
        endfunction

        function void check_result(logic [63:0] blk, logic [1:0] st);
            cipher_word_t w;
            if (pending_words.size() == 0)
            begin
                $error("result word with nothing pending: result_block %h status %0d", blk, st);
                errors++;
                return;
            end
            w = pending_words.pop_front();
            if (blk !== w.blk)
            begin
                $error("result_block: expected %h, actual %h", w.blk, blk);
                errors++;
            end
            if (st !== w.st)
            begin
                $error("status: expected %0d, actual %0d", w.st, st);
                errors++;
            end
        endfunction
    endclass

    rc2_scoreboard sb;
    bit            in_calm     = 1'b0;
    bit            out_calm    = 1'b0;
    int            ready_hold  = 0;
    int            idle_cycles = 0;

    rc2_block_cipher_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .operation    (operation),
        .key_position (key_position),
        .key_byte     (key_byte),
        .data_block   (data_block),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_block (result_block),
        .status       (status),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    // receiver: after each word taken, hold ready low for a drawn number of
    // cycles in which a word is on offer
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            sb.check_result(result_block, status);
            if ($urandom_range(0, 39) == 0) out_calm = !out_calm;
            ready_hold = out_calm ? 0 : $urandom_range(0, 6);
            out_ready <= (ready_hold == 0);
        end
        else if (rst_n && out_valid && ready_hold > 0)
        begin
            ready_hold--;
            out_ready <= (ready_hold == 0);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("rc2_block_cipher_unit verification failed");
            $finish;
        end
    end

    function automatic bit [63:0] random_block();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // called at a clock edge; returns at the edge that accepts the word
    task automatic send_word(op_t op, bit [6:0] pos, bit [7:0] kb, bit [63:0] blk);
        int gap;
        if ($urandom_range(0, 39) == 0) in_calm = !in_calm;
        gap = in_calm ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        operation    <= op;
        key_position <= pos;
        key_byte     <= kb;
        data_block   <= blk;
        do @(posedge clk); while (!in_ready);
        sb.note_input(op, pos, kb, blk);
    endtask

    // drop valid, wait for every pending word, then let a trailing load finish
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending_words.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apply_setting(int sel);
        bit [10:0] len_word, eff_word;
        len_word = {3'($urandom), 8'($urandom)};
        eff_word = 11'($urandom);
        case (sel)
            0:
            begin
                len_word[7:0] = 8'd1;
                eff_word      = 11'd1;
            end
            1:
            begin
                len_word[7:0] = 8'd128;
                eff_word      = 11'd1024;
            end
            2:
            begin
                len_word[7:0] = 8'd0;
                eff_word      = 11'd0;
            end
            3:
            begin
                len_word[7:0] = 8'd255;
                eff_word      = 11'd2047;
            end
            default: ;
        endcase
        settle();
        cfg_write <= 1'b1;
        cfg_index <= CFG_KEY_LEN;
        cfg_data  <= len_word;
        @(posedge clk);
        cfg_index <= CFG_EFF_BITS;
        cfg_data  <= eff_word;
        @(posedge clk);
        cfg_write <= 1'b0;
        sb.write_reg(len_word[7:0], eff_word);
    endtask

    initial
    begin
        int t_bytes, n;
        sb = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // no key yet: block commands are refused
        send_word(OP_ENCRYPT, 7'h00, 8'h00, '0);
        send_word(OP_ENCRYPT, 7'h7f, 8'hff, '1);
        send_word(OP_DECRYPT, 7'h00, 8'h00, '0);
        send_word(OP_DECRYPT, 7'h7f, 8'hff, '1);
        send_word(OP_LOAD, 7'h00, 8'h00, '1);
        send_word(OP_LOAD, 7'h7f, 8'hff, '0);
        send_word(OP_LOAD, 7'h55, 8'haa, 64'haaaa_aaaa_aaaa_aaaa);
        send_word(OP_LOAD, 7'h2a, 8'h55, 64'h5555_5555_5555_5555);

        for (int ph = 0; ph < 2; ph++)
        begin
            apply_setting(1 - ph);
            repeat (60)
            begin
                case ($urandom_range(0, 3))
                    0, 1: send_word(OP_LOAD, 7'($urandom), 8'($urandom), random_block());
                    2:    send_word(OP_ENCRYPT, 7'($urandom), 8'($urandom), random_block());
                    default:
                        send_word(OP_DECRYPT, 7'($urandom), 8'($urandom), random_block());
                endcase
            end
        end

        // pick the expansion setting, then fill every key byte it reads
        apply_setting($urandom_range(0, 7));
        t_bytes = (sb.key_len == 0) ? 1 : (sb.key_len > 128) ? 128 : sb.key_len;
        for (int p = 0; p < t_bytes; p++)
            if (!sb.loaded[p] || $urandom_range(0, 3) == 0)
                send_word(OP_LOAD, 7'(p), 8'($urandom), random_block());
        send_word(OP_EXPAND, 7'($urandom), 8'($urandom), random_block());
        send_word(OP_EXPAND, 7'($urandom), 8'($urandom), random_block());
        send_word(OP_ENCRYPT, 7'h00, 8'h00, '0);
        send_word(OP_ENCRYPT, 7'h7f, 8'hff, '1);
        send_word(OP_DECRYPT, 7'h00, 8'h00, sb.last_cipher);
        send_word(OP_DECRYPT, 7'h7f, 8'hff, '1);
        send_word(OP_DECRYPT, 7'h2a, 8'h55, '0);
        // a load after expansion must leave the subkeys alone
        send_word(OP_LOAD, 7'h00, 8'($urandom), random_block());
        send_word(OP_ENCRYPT, 7'h00, 8'h00, 64'h0123_4567_89ab_cdef);

        for (int ph = 0; ph < 6; ph++)
        begin
            apply_setting(ph % 5);
            repeat (110)
            begin
                n = $urandom_range(0, 99);
                if (n < 8)
                    send_word(OP_LOAD, 7'($urandom), 8'($urandom), random_block());
                else if (n < 14)
                    send_word(OP_EXPAND, 7'($urandom), 8'($urandom), random_block());
                else if (n < 55)
                    send_word(OP_ENCRYPT, 7'($urandom), 8'($urandom), random_block());
                else if (n < 70)
                    send_word(OP_DECRYPT, 7'($urandom), 8'($urandom), sb.last_cipher);
                else
                    send_word(OP_DECRYPT, 7'($urandom), 8'($urandom), random_block());
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending_words.size() == 0)
            $display("rc2_block_cipher_unit verification clean");
        else
            $display("rc2_block_cipher_unit verification failed");
        $finish;
    end
endmodule
